[design/tcv_pkg.sv]
// ----------------------------------------------------------------------------
// tcv_pkg - shared types and functions of the trailer checksum verifier
// Marker text, hash step, marker matcher step and the queue word between the
// front and back parts.
// ----------------------------------------------------------------------------
package tcv_pkg;

   localparam int MARK_LEN   = 9;
   localparam int HASH_MUL   = 31;
   localparam int HASH_MOD   = 100000;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] MARK_TEXT [MARK_LEN] =
      '{"C", "H", "E", "C", "K", "S", "U", "M", ":"};

   // word passed from the front part to the back part
   typedef struct packed {
      logic                   hash_op;     // fold hash_byte into the hash
      logic [7:0]             hash_byte;
      logic                   finish;      // end of stream: report a result
      logic                   found;
      logic                   valid;
      logic [31:0]            value;
      logic [3:0]             flush_cnt;   // delay line bytes still to hash
      logic [MARK_LEN*8-1:0]  flush_bytes; // oldest byte in the low bits
   } tcv_entry_type;

   // hash = (hash*31 + signed byte) mod 100000, remainder truncated toward zero
   function automatic logic signed [17:0] hash_step(input logic signed [17:0] h,
                                                   input logic [7:0] b);
      logic signed [23:0] hx;
      logic signed [23:0] sx;
      logic signed [23:0] x;
      logic [21:0]        mag;
      hx = 24'(h);
      sx = 24'($signed(b));
      x  = hx * 24'(HASH_MUL) + sx;
      mag = x[23] ? 22'(-x) : 22'(x);
      // |x| < 32 * modulus: five restoring steps give the remainder
      for (int k = 4; k >= 0; k--) begin
         if (mag >= (22'(HASH_MOD) << k)) begin
            mag = mag - (22'(HASH_MOD) << k);
         end
      end
      return x[23] ? -$signed(18'(mag)) : $signed(18'(mag));
   endfunction

   // next matcher progress, with fall back on the prefix C after CHEC
   function automatic logic [3:0] match_next(input logic [3:0] p, input logic [7:0] b);
      logic [3:0] q;
      if (p < 4'(MARK_LEN) && b == MARK_TEXT[p]) begin
         return p + 4'd1;
      end
      q = (p == 4'd4) ? 4'd1 : 4'd0;
      if (b == MARK_TEXT[q]) begin
         return q + 4'd1;
      end
      return 4'd0;
   endfunction

endpackage

[design/tcv_front.sv]
// ----------------------------------------------------------------------------
// tcv_front - byte classifier
// Runs the marker matcher, the nine-byte delay line and the trailer parser,
// and issues hash and finish words to the back part.
// ----------------------------------------------------------------------------
module tcv_front import tcv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output logic          push,
   output tcv_entry_type entry
);

   typedef enum logic [5:0] {
      PH_SEARCH   = 6'b000001,
      PH_SKIP_WS  = 6'b000010,
      PH_SIGN     = 6'b000100,
      PH_DIGITS   = 6'b001000,
      PH_DONE_DIG = 6'b010000,
      PH_DONE_BAD = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  delay_ff [MARK_LEN];
   logic [7:0]  delay_in [MARK_LEN];
   logic [3:0]  fill_ff, fill_in;
   logic [3:0]  prog_ff, prog_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;

   logic        is_digit;
   logic        is_space;
   logic        take;
   logic [34:0] mag_grown;
   logic        found;
   logic        valid;

   assign is_digit  = (data_byte >= "0") && (data_byte <= "9");
   assign is_space  = (data_byte == " ") || ((data_byte >= 8'd9) && (data_byte <= 8'd13));
   assign mag_grown = (35'(mag_ff) << 3) + (35'(mag_ff) << 1) + 35'(data_byte - "0");

   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      fill_in  = fill_ff;
      prog_in  = prog_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      take     = 1'b0;
      entry.hash_op   = 1'b0;
      entry.hash_byte = delay_ff[0];
      unique case (phase_ff)
         PH_SEARCH: begin
            if (fill_ff >= 4'(MARK_LEN)) begin
               entry.hash_op = 1'b1;
               for (int i = 0; i < MARK_LEN - 1; i++) begin
                  delay_in[i] = delay_ff[i+1];
               end
               delay_in[MARK_LEN-1] = data_byte;
            end else begin
               delay_in[fill_ff] = data_byte;
               fill_in = fill_ff + 4'd1;
            end
            prog_in = match_next(prog_ff, data_byte);
            if (prog_in >= 4'(MARK_LEN)) begin
               prog_in  = 4'd0;
               phase_in = PH_SKIP_WS;
            end
         end
         PH_SKIP_WS: begin
            if (!is_space) begin
               if (data_byte == "+" || data_byte == "-") begin
                  neg_in   = (data_byte == "-");
                  phase_in = PH_SIGN;
               end else if (is_digit) begin
                  take     = 1'b1;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_DONE_BAD;
               end
            end
         end
         PH_SIGN: begin
            if (is_digit) begin
               take     = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE_BAD;
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               take = 1'b1;
            end else begin
               phase_in = PH_DONE_DIG;
            end
         end
         PH_DONE_DIG, PH_DONE_BAD: begin
         end
         default: begin
            phase_in = PH_SEARCH;
         end
      endcase
      // stop growing the magnitude once it would pass 2^31
      if (take && !ovf_ff) begin
         if (mag_grown > 35'h0_8000_0000) begin
            ovf_in = 1'b1;
         end else begin
            mag_in = mag_grown[31:0];
         end
      end
      found = (phase_in != PH_SEARCH);
      valid = found && (phase_in == PH_DIGITS || phase_in == PH_DONE_DIG) && !ovf_in
              && !(!neg_in && mag_in[31]);
      entry.finish    = last_byte;
      entry.found     = found;
      entry.valid     = valid;
      entry.value     = valid ? (neg_in ? 32'(0) - mag_in : mag_in) : 32'd0;
      entry.flush_cnt = found ? 4'd0 : fill_in;
      for (int i = 0; i < MARK_LEN; i++) begin
         entry.flush_bytes[i*8 +: 8] = delay_in[i];
      end
   end

   assign push = accept && (entry.hash_op || last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         fill_ff  <= 4'd0;
         prog_ff  <= 4'd0;
         mag_ff   <= 32'd0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         if (last_byte) begin
            // end of stream: start over for the next one
            phase_ff <= PH_SEARCH;
            fill_ff  <= 4'd0;
            prog_ff  <= 4'd0;
            mag_ff   <= 32'd0;
            neg_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            fill_ff  <= fill_in;
            prog_ff  <= prog_in;
            mag_ff   <= mag_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         delay_ff <= delay_in;
      end
   end

endmodule

[design/tcv_queue.sv]
// ----------------------------------------------------------------------------
// tcv_queue - word queue between front and back parts
// Small first-in first-out buffer; the head word is shown while not empty.
// ----------------------------------------------------------------------------
module tcv_queue import tcv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tcv_entry_type push_word,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output tcv_entry_type head_word
);

   tcv_entry_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[design/tcv_back.sv]
// ----------------------------------------------------------------------------
// tcv_back - hash unit and result stage
// Folds queued bytes into the running hash, drains the delay line at the end
// of a stream without a marker, and holds the result word for the consumer.
// ----------------------------------------------------------------------------
module tcv_back import tcv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  tcv_entry_type       q_word,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic                rsp_checksum_ok,
   output logic                rsp_marker_found,
   output logic                rsp_number_valid,
   output logic signed [17:0]  rsp_computed_hash,
   output logic signed [31:0]  rsp_stored_value
);

   typedef enum logic [1:0] {
      BK_RUN   = 2'b01,
      BK_FLUSH = 2'b10
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic signed [17:0] hash_ff, hash_in;
   logic [7:0]         flush_ff [MARK_LEN];
   logic [7:0]         flush_in [MARK_LEN];
   logic [3:0]         left_ff, left_in;
   logic               out_valid_ff, out_valid_in;
   logic               ok_ff, ok_in;
   logic               found_ff, found_in;
   logic               nv_ff, nv_in;
   logic signed [17:0] res_hash_ff, res_hash_in;
   logic signed [31:0] value_ff, value_in;

   logic               out_free;
   logic [7:0]         step_byte;
   logic signed [17:0] step_hash;
   logic signed [17:0] run_hash;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign step_byte = (state_ff == BK_FLUSH) ? flush_ff[0] : q_word.hash_byte;
   assign step_hash = hash_step(hash_ff, step_byte);
   assign run_hash  = q_word.hash_op ? step_hash : hash_ff;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      flush_in     = flush_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      ok_in        = ok_ff;
      found_in     = found_ff;
      nv_in        = nv_ff;
      res_hash_in  = res_hash_ff;
      value_in     = value_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         BK_RUN: begin
            if (!q_empty) begin
               if (!q_word.finish) begin
                  q_pop   = 1'b1;
                  hash_in = run_hash;
               end else if (q_word.found || q_word.flush_cnt == 4'd0) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     hash_in      = 18'sd0;
                     out_valid_in = 1'b1;
                     ok_in        = q_word.valid && (q_word.value == 32'(run_hash));
                     found_in     = q_word.found;
                     nv_in        = q_word.valid;
                     res_hash_in  = run_hash;
                     value_in     = q_word.value;
                  end
               end else begin
                  // no marker: drain the delay line one byte a cycle, the last one once the result slot is free
                  q_pop    = 1'b1;
                  hash_in  = run_hash;
                  left_in  = q_word.flush_cnt;
                  state_in = BK_FLUSH;
                  for (int i = 0; i < MARK_LEN; i++) begin
                     flush_in[i] = q_word.flush_bytes[i*8 +: 8];
                  end
               end
            end
         end
         BK_FLUSH: begin
            if (left_ff == 4'd1) begin
               if (out_free) begin
                  hash_in      = 18'sd0;
                  state_in     = BK_RUN;
                  out_valid_in = 1'b1;
                  ok_in        = 1'b0;
                  found_in     = 1'b0;
                  nv_in        = 1'b0;
                  res_hash_in  = step_hash;
                  value_in     = 32'sd0;
               end
            end else begin
               hash_in = step_hash;
               left_in = left_ff - 4'd1;
               for (int i = 0; i < MARK_LEN - 1; i++) begin
                  flush_in[i] = flush_ff[i+1];
               end
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         hash_ff      <= 18'sd0;
         out_valid_ff <= 1'b0;
         left_ff      <= 4'd0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_ff    <= flush_in;
      ok_ff       <= ok_in;
      found_ff    <= found_in;
      nv_ff       <= nv_in;
      res_hash_ff <= res_hash_in;
      value_ff    <= value_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_checksum_ok   = ok_ff;
   assign rsp_marker_found  = found_ff;
   assign rsp_number_valid  = nv_ff;
   assign rsp_computed_hash = res_hash_ff;
   assign rsp_stored_value  = value_ff;

endmodule

[design/trailer_checksum_verifier_top.sv]
// Result path: a result reaches the result ports through the queue and the result register
//   once its last byte is taken; without a marker the back part first drains the delay
//   line, one held byte at a time (up to 9 bytes).
// Throughput: 1 byte per cycle; the hash unit in the back part sets this rate. A drain
//   or a held result stalls the input once the four-word queue fills.
// Reset: synchronous, active high; clears the queue, the parser and the hash.
// ----------------------------------------------------------------------------
// trailer_checksum_verifier_top - save file trailer checksum check
// Hashes the bytes before the CHECKSUM: marker, parses the trailer number and
// reports one result word per stream.
// ----------------------------------------------------------------------------
module trailer_checksum_verifier_top import tcv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic                rsp_checksum_ok,
   output logic                rsp_marker_found,
   output logic                rsp_number_valid,
   output logic signed [17:0]  rsp_computed_hash,
   output logic signed [31:0]  rsp_stored_value
);

   logic          accept;
   logic          f_push;
   tcv_entry_type f_word;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   tcv_entry_type q_word;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   tcv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (f_push),
      .entry     (f_word)
   );

   tcv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_word (f_word),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_word (q_word)
   );

   tcv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_word            (q_word),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_marker_found  (rsp_marker_found),
      .rsp_number_valid  (rsp_number_valid),
      .rsp_computed_hash (rsp_computed_hash),
      .rsp_stored_value  (rsp_stored_value)
   );

endmodule

[tb/trailer_checksum_verifier_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trailer_checksum_verifier_top_tb - self-checking bench for the trailer check
// Streams save files byte by byte: a few hand-picked files, then random ones
// built around the CHECKSUM: marker, then a long output stall that fills the
// block. A tracker mirrors the hash, the marker search and the trailer parse,
// and every reported word is compared field by field with its prediction.
// ----------------------------------------------------------------------------
module trailer_checksum_verifier_top_tb;
   import tcv_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 240;
   localparam int RANDOM_FILES = 15;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 300;

   typedef enum int {
      SCAN_MARKER, SKIP_SPACE, SIGN_SEEN, IN_DIGITS, DIGITS_DONE, NO_DIGITS
   } trailer_phase_type;

   typedef struct {
      logic               ok;
      logic               found;
      logic               valid;
      logic signed [17:0] hash;
      logic signed [31:0] value;
   } verdict_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_pop = 1'b0;
   logic               rsp_empty;
   logic               rsp_checksum_ok;
   logic               rsp_marker_found;
   logic               rsp_number_valid;
   logic signed [17:0] rsp_computed_hash;
   logic signed [31:0] rsp_stored_value;

   // expected report words, oldest first
   verdict_type        expected_verdicts [$];
   logic [7:0]         file_bytes [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 bytes_sent = 0;
   bit                 gaps_on = 1'b1;
   int                 burst_left = 0;
   bit                 hold_req = 1'b0;
   bit                 hold_ack = 1'b0;
   int                 hold_left = 0;
   logic [15:0]        pop_pattern = 16'hffff;
   int                 pattern_step = 0;

   // tracker state
   int                 pre_hash;
   logic [7:0]         held_bytes [MARK_LEN];
   int                 held_count;
   int                 marker_pos;
   trailer_phase_type  phase;
   longint unsigned    magnitude;
   bit                 negative;
   bit                 overflow;

   trailer_checksum_verifier_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_marker_found  (rsp_marker_found),
      .rsp_number_valid  (rsp_number_valid),
      .rsp_computed_hash (rsp_computed_hash),
      .rsp_stored_value  (rsp_stored_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int fold_byte(int h, logic [7:0] b);
      // SV remainder truncates toward zero, so the hash keeps its sign
      return (h * HASH_MUL + int'($signed(b))) % HASH_MOD;
   endfunction

   function automatic int next_marker_pos(int p, logic [7:0] b);
      int restart;
      if (p < MARK_LEN && b == MARK_TEXT[p]) begin
         return p + 1;
      end
      // after CHEC, retry as if only the leading C had matched
      restart = (p == 4) ? 1 : 0;
      return (b == MARK_TEXT[restart]) ? restart + 1 : 0;
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   task automatic clear_tracker;
      pre_hash   = 0;
      held_count = 0;
      marker_pos = 0;
      phase      = SCAN_MARKER;
      magnitude  = 0;
      negative   = 1'b0;
      overflow   = 1'b0;
      foreach (held_bytes[i]) held_bytes[i] = 8'h00;
   endtask

   task automatic add_digit(input logic [7:0] c);
      longint unsigned m;
      m = magnitude * 10 + (c - "0");
      if (!overflow) begin
         if (m > 64'd2147483648) overflow = 1'b1;
         else magnitude = m;
      end
   endtask

   task automatic track_byte(input logic [7:0] b, input logic last);
      verdict_type v;
      int          h;
      logic [31:0] val;
      if (phase == SCAN_MARKER) begin
         // hold the newest bytes back so marker text never reaches the hash
         if (held_count >= MARK_LEN) begin
            pre_hash = fold_byte(pre_hash, held_bytes[0]);
            for (int i = 0; i < MARK_LEN - 1; i++) held_bytes[i] = held_bytes[i + 1];
            held_bytes[MARK_LEN - 1] = b;
         end else begin
            held_bytes[held_count] = b;
            held_count++;
         end
         marker_pos = next_marker_pos(marker_pos, b);
         if (marker_pos >= MARK_LEN) begin
            marker_pos = 0;
            phase = SKIP_SPACE;
         end
      end else begin
         case (phase)
            SKIP_SPACE: begin
               if (!is_blank(b)) begin
                  if (b == "+" || b == "-") begin
                     negative = (b == "-");
                     phase = SIGN_SEEN;
                  end else if (is_digit(b)) begin
                     add_digit(b);
                     phase = IN_DIGITS;
                  end else begin
                     phase = NO_DIGITS;
                  end
               end
            end
            SIGN_SEEN: begin
               if (is_digit(b)) begin
                  add_digit(b);
                  phase = IN_DIGITS;
               end else begin
                  phase = NO_DIGITS;
               end
            end
            IN_DIGITS: begin
               if (is_digit(b)) add_digit(b);
               else phase = DIGITS_DONE;
            end
            default: ;
         endcase
      end
      if (last) begin
         v.found = (phase != SCAN_MARKER);
         v.valid = (phase == IN_DIGITS || phase == DIGITS_DONE) && !overflow &&
                   !(!negative && magnitude > 64'd2147483647);
         h = pre_hash;
         // no marker: the held bytes belong to the hash too
         if (!v.found) begin
            for (int i = 0; i < held_count; i++) h = fold_byte(h, held_bytes[i]);
         end
         val = '0;
         if (v.valid) val = negative ? 32'(-magnitude) : 32'(magnitude);
         v.ok    = v.valid && (val == 32'(h));
         v.hash  = 18'(h);
         v.value = val;
         expected_verdicts.push_back(v);
         clear_tracker();
      end
   endtask

   task automatic push_word(input logic [7:0] b, input logic last);
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_full);
      track_byte(b, last);
      bytes_sent++;
      if (gaps_on && burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 8);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   task automatic send_file;
      for (int i = 0; i < file_bytes.size(); i++) begin
         push_word(file_bytes[i], i == file_bytes.size() - 1);
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endtask

   function automatic logic [7:0] blank_byte();
      int pick;
      pick = $urandom_range(0, 5);
      return (pick == 0) ? 8'h20 : 8'(8 + pick);
   endfunction

   function automatic logic [7:0] bad_lead_byte();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) return 8'h00;
      do c = 8'($urandom); while (is_blank(c) || is_digit(c) || c == "+" || c == "-");
      return c;
   endfunction

   function automatic longint pick_number();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 64'sd2147483647;
         2: return -64'sd2147483648;
         3: return 64'sd2147483648;
         4: return -64'sd2147483649;
         5: return longint'(int'($urandom));
         default: return longint'($urandom_range(0, 199998)) - 99999;
      endcase
   endfunction

   task automatic build_random_file;
      int     kind;
      int     prefix_hash;
      longint num;
      string  digits;
      file_bytes.delete();
      repeat ($urandom_range(0, 8)) begin
         file_bytes.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(65, 90)));
      end
      // partial marker text right before the real one exercises the fallback
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: add_text("CHE");
            1: add_text("CHEC");
            2: add_text("CHECKS");
            default: add_text("CHECKSUM");
         endcase
      end
      prefix_hash = 0;
      foreach (file_bytes[i]) prefix_hash = fold_byte(prefix_hash, file_bytes[i]);
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         add_text("CHECKSUM:");
         repeat ($urandom_range(0, 2)) file_bytes.push_back(blank_byte());
         num = (kind <= 2) ? longint'(prefix_hash) : pick_number();
         digits = $sformatf("%0d", num);
         if (num >= 0 && $urandom_range(0, 2) == 0) digits = {"+", digits};
         add_text(digits);
         case ($urandom_range(0, 3))
            1: repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
            2: add_text(" CHECKSUM:1");
            3: file_bytes.push_back(8'h0a);
            default: ;
         endcase
      end else if (kind == 6) begin
         repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
      end else if (kind == 7) begin
         add_text("CHECKSUM:");
      end else if (kind == 8) begin
         add_text("CHECKSUM:");
         repeat ($urandom_range(0, 2)) file_bytes.push_back(blank_byte());
         case ($urandom_range(0, 3))
            0: add_text("-");
            1: begin
               add_text($urandom_range(0, 1) ? "+" : "-");
               file_bytes.push_back(bad_lead_byte());
            end
            2: begin
               file_bytes.push_back(bad_lead_byte());
               add_text("12");
            end
            default: file_bytes.push_back(blank_byte());
         endcase
      end else begin
         add_text("CHECKSUM:");
         if ($urandom_range(0, 1)) add_text("-");
         file_bytes.push_back(8'($urandom_range(49, 57)));
         repeat ($urandom_range(9, 12)) file_bytes.push_back(8'($urandom_range(48, 57)));
      end
      if (file_bytes.size() == 0) file_bytes.push_back(8'($urandom));
   endtask

   task automatic test_stream_edges;
      // no marker, byte extremes: the held bytes must be folded in at the end
      file_bytes = '{8'h00, 8'hff, 8'h80, 8'h7f};
      send_file();
      // marker on the final byte leaves an empty trailer
      file_bytes.delete();
      add_text("CHECKSUM:");
      send_file();
      file_bytes.delete();
      add_text("CHECKSUM:+0");
      send_file();
   endtask

   task automatic test_random_files;
      int files;
      int first_byte;
      files = 0;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < RANDOM_BYTES || files < RANDOM_FILES) begin
         build_random_file();
         send_file();
         files++;
      end
   endtask

   task automatic test_output_backpressure;
      gaps_on = 1'b0;
      hold_req = ~hold_req;
      repeat (16) begin
         file_bytes.delete();
         if ($urandom_range(0, 1)) begin
            file_bytes.push_back(8'($urandom));
         end else begin
            add_text("CHECKSUM:");
            add_text($sformatf("%0d", $urandom_range(0, 99)));
         end
         send_file();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      clear_tracker();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_stream_edges();
      test_random_files();
      test_output_backpressure();
      req_push <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_verdicts.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_checksum_ok !== want.ok) begin
               $error("checksum_ok: expected %0d, got %0d", want.ok, rsp_checksum_ok);
               error_count++;
            end
            if (rsp_marker_found !== want.found) begin
               $error("marker_found: expected %0d, got %0d", want.found, rsp_marker_found);
               error_count++;
            end
            if (rsp_number_valid !== want.valid) begin
               $error("number_valid: expected %0d, got %0d", want.valid, rsp_number_valid);
               error_count++;
            end
            if (rsp_computed_hash !== want.hash) begin
               $error("computed_hash: expected %0d, got %0d", want.hash, rsp_computed_hash);
               error_count++;
            end
            if (rsp_stored_value !== want.value) begin
               $error("stored_value: expected %0d, got %0d", want.value, rsp_stored_value);
               error_count++;
            end
         end
      end
      // long hold-off on request, otherwise walk a rotating stall pattern
      if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
         pattern_step++;
         if (pattern_step == 16) begin
            pattern_step = 0;
            pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
         end
      end
   end

endmodule

[filelist.f]
design/tcv_pkg.sv
design/tcv_front.sv
design/tcv_queue.sv
design/tcv_back.sv
design/trailer_checksum_verifier_top.sv
tb/trailer_checksum_verifier_top_tb.sv
